// ===== rtl/biss_c_position_decoder_assert.svh =====
// assertion macros for the biss-c position decoder
`ifndef BISS_C_POSITION_DECODER_ASSERT_SVH
`define BISS_C_POSITION_DECODER_ASSERT_SVH

// same-cycle implication
`define BISSC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("biss-c decoder assertion failed");

// next-cycle implication
`define BISSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("biss-c decoder assertion failed");

`endif

// ===== rtl/bissc_pkg.sv =====
// shared constants and types for the biss-c position decoder
package bissc_pkg;

    localparam int FRAME_W        = 64;
    localparam int SYNC_BITS      = 3;
    localparam int WORD_SHIFT     = 3;
    localparam int SYNC_POS_W     = 6;
    localparam int SPEED_W        = 24;
    localparam int PP_W           = 5;
    localparam int CFG_INDEX_W    = 2;

    localparam int FRAME_BITS_DEF = 64;
    localparam int DATA_BITS_DEF  = 35;
    localparam int POS_BITS_DEF   = 20;

    // rpm * 256 for one turn per 1 ms period
    localparam logic [SPEED_W-1:0] RPM_Q8_PER_TURN = 24'd15360000;

    localparam logic [23:0]     ELEC_OFFSET_RESET = 24'd204560;
    localparam logic [PP_W-1:0] POLE_PAIRS_RESET  = 5'd5;

    localparam logic [CFG_INDEX_W-1:0] REG_ELEC_OFFSET = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_POLE_PAIRS  = 2'd1;

    typedef struct packed {
        logic                  found;
        logic [SYNC_POS_W-1:0] sync_idx;
        logic                  first;
    } status_t;

endpackage

// ===== rtl/bissc_frame_decode.sv =====
// sync search, data extraction and position state stage
module bissc_frame_decode #(
    parameter int FRAME_BITS = bissc_pkg::FRAME_BITS_DEF,
    parameter int DATA_BITS  = bissc_pkg::DATA_BITS_DEF,
    parameter int POS_BITS   = bissc_pkg::POS_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s0_valid,
    input  logic [bissc_pkg::FRAME_W-1:0] frame,
    output logic                         s1_ready,
    output logic                         s1_valid,
    input  logic                         s2_ready,
    output bissc_pkg::status_t           status,
    output logic [POS_BITS-1:0]          pos_out,
    output logic [POS_BITS-1:0]          prev_out
);

    localparam int FW    = bissc_pkg::FRAME_W;
    localparam int EXT_W = FW + DATA_BITS;
    localparam int SH_W  = $clog2(FW + bissc_pkg::SYNC_BITS + 1);

    logic                             s1_valid_reg;
    bissc_pkg::status_t               status_reg;
    logic [POS_BITS-1:0]              pos_reg;
    logic [POS_BITS-1:0]              prev_reg;
    logic                             started_reg;

    logic [FW-1:0]                    frame_mask;
    logic [FW-1:0]                    frame_kept;
    logic                             found_next;
    logic [bissc_pkg::SYNC_POS_W-1:0] sync_pos_next;
    logic [SH_W-1:0]                  shamt;
    logic [EXT_W-1:0]                 ext;
    logic [EXT_W-1:0]                 shifted;
    logic [DATA_BITS-1:0]             word;
    logic [POS_BITS-1:0]              pos_next;
    logic                             load;

    // bits past the frame read as zero
    assign frame_mask = ~({FW{1'b1}} >> FRAME_BITS);
    assign frame_kept = frame & frame_mask;

    // first 0-1-0 pattern, lowest index wins
    always_comb
    begin
        found_next    = 1'b0;
        sync_pos_next = '0;
        for (int i = FRAME_BITS - 3; i >= 0; i--)
        begin
            if (!frame_kept[FW-1-i] && frame_kept[FW-2-i] && !frame_kept[FW-3-i])
            begin
                found_next    = 1'b1;
                sync_pos_next = bissc_pkg::SYNC_POS_W'(i);
            end
        end
    end

    assign shamt    = SH_W'(sync_pos_next) + SH_W'(bissc_pkg::SYNC_BITS);
    assign ext      = {frame_kept, {DATA_BITS{1'b0}}};
    assign shifted  = ext << shamt;
    assign word     = shifted[EXT_W-1 -: DATA_BITS];
    assign pos_next = found_next ? word[bissc_pkg::WORD_SHIFT +: POS_BITS] : pos_reg;

    assign s1_ready = !s1_valid_reg || s2_ready;
    assign load     = s0_valid && s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            pos_reg      <= '0;
            started_reg  <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= s0_valid;
            end
            if (load)
            begin
                pos_reg     <= pos_next;
                started_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prev_reg            <= pos_reg;
            status_reg.found    <= found_next;
            status_reg.sync_idx <= sync_pos_next;
            status_reg.first    <= !started_reg;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign status   = status_reg;
    assign pos_out  = pos_reg;
    assign prev_out = prev_reg;

endmodule

// ===== rtl/bissc_motion.sv =====
// speed and electrical angle stage with output register
module bissc_motion #(
    parameter int POS_BITS = bissc_pkg::POS_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s1_valid,
    output logic                                s2_ready,
    input  bissc_pkg::status_t                  status,
    input  logic [POS_BITS-1:0]                 pos_in,
    input  logic [POS_BITS-1:0]                 prev_in,
    input  logic [POS_BITS-1:0]                 elec_offset,
    input  logic [bissc_pkg::PP_W-1:0]          pole_pairs,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                sync_found,
    output logic [bissc_pkg::SYNC_POS_W-1:0]    sync_position,
    output logic [POS_BITS-1:0]                 position,
    output logic signed [bissc_pkg::SPEED_W-1:0] speed_rpm_q8,
    output logic [POS_BITS-1:0]                 elec_angle
);

    localparam int SW     = bissc_pkg::SPEED_W;
    localparam int PROD_W = POS_BITS + SW + 1;

    logic                             out_valid_reg;
    logic                             found_reg;
    logic [bissc_pkg::SYNC_POS_W-1:0] sync_pos_reg;
    logic [POS_BITS-1:0]              position_reg;
    logic [SW-1:0]                    speed_reg;
    logic [POS_BITS-1:0]              angle_reg;

    logic [POS_BITS-1:0]              delta;
    logic signed [PROD_W-1:0]         speed_prod;
    logic signed [PROD_W-1:0]         speed_shift;
    logic [SW-1:0]                    speed_next;
    logic [POS_BITS-1:0]              angle_diff;
    logic [POS_BITS+bissc_pkg::PP_W-1:0] angle_prod;
    logic [POS_BITS-1:0]              angle_next;
    logic                             load;

    // wrapped position change, taken as signed
    assign delta       = pos_in - prev_in;
    assign speed_prod  = $signed(delta) * $signed({1'b0, bissc_pkg::RPM_Q8_PER_TURN});
    assign speed_shift = speed_prod >>> POS_BITS;
    assign speed_next  = status.first ? '0 : speed_shift[SW-1:0];

    assign angle_diff = pos_in - elec_offset;
    assign angle_prod = angle_diff * pole_pairs;
    assign angle_next = angle_prod[POS_BITS-1:0];

    assign s2_ready = !out_valid_reg || !out_stall;
    assign load     = s1_valid && s2_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            out_valid_reg <= s1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            found_reg    <= status.found;
            sync_pos_reg <= status.found ? status.sync_idx : '0;
            position_reg <= pos_in;
            speed_reg    <= speed_next;
            angle_reg    <= angle_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign sync_found    = found_reg;
    assign sync_position = sync_pos_reg;
    assign position      = position_reg;
    assign speed_rpm_q8  = $signed(speed_reg);
    assign elec_angle    = angle_reg;

endmodule

// ===== rtl/biss_c_position_decoder.sv =====
// biss-c position decoder top level: input register, configuration and stages
//
// channel   direction  handshake              payload
// in        input      in_valid / in_stall    frame
// out       output     out_valid / out_stall  sync_found, sync_position, position,
//                                             speed_rpm_q8, elec_angle
// cfg       input      cfg_we                 cfg_index, cfg_wdata
//
// one transaction per cycle sustained while out_stall is low
// three register stages: input register, decode stage, output register
// each stage fills while the next one waits, so in_stall rises only when all are full
// reset clears the valid bits, the stored position and the first-sample flag
// configuration takes effect on the next transaction that reaches the output stage
module biss_c_position_decoder #(
    parameter int FRAME_BITS = bissc_pkg::FRAME_BITS_DEF,
    parameter int DATA_BITS  = bissc_pkg::DATA_BITS_DEF,
    parameter int POS_BITS   = bissc_pkg::POS_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [bissc_pkg::FRAME_W-1:0]        frame,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 sync_found,
    output logic [bissc_pkg::SYNC_POS_W-1:0]     sync_position,
    output logic [POS_BITS-1:0]                  position,
    output logic signed [bissc_pkg::SPEED_W-1:0] speed_rpm_q8,
    output logic [POS_BITS-1:0]                  elec_angle,
    input  logic                                 cfg_we,
    input  logic [bissc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [POS_BITS-1:0]                  cfg_wdata
);

`include "biss_c_position_decoder_assert.svh"

    logic                              s0_valid_reg;
    logic [bissc_pkg::FRAME_W-1:0]     frame_reg;
    logic [POS_BITS-1:0]               elec_offset_reg;
    logic [bissc_pkg::PP_W-1:0]        pole_pairs_reg;

    logic                              s0_ready;
    logic                              s1_ready;
    logic                              s1_valid;
    logic                              s2_ready;
    bissc_pkg::status_t                status;
    logic [POS_BITS-1:0]               pos_s1;
    logic [POS_BITS-1:0]               prev_s1;

    assign s0_ready = !s0_valid_reg || s1_ready;
    assign in_stall = !s0_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg    <= 1'b0;
            elec_offset_reg <= POS_BITS'(bissc_pkg::ELEC_OFFSET_RESET);
            pole_pairs_reg  <= bissc_pkg::POLE_PAIRS_RESET;
        end
        else
        begin
            if (s0_ready)
            begin
                s0_valid_reg <= in_valid;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    bissc_pkg::REG_ELEC_OFFSET: elec_offset_reg <= cfg_wdata;
                    bissc_pkg::REG_POLE_PAIRS:  pole_pairs_reg  <= cfg_wdata[bissc_pkg::PP_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && s0_ready)
        begin
            frame_reg <= frame;
        end
    end

    bissc_frame_decode #(
        .FRAME_BITS (FRAME_BITS),
        .DATA_BITS  (DATA_BITS),
        .POS_BITS   (POS_BITS)
    ) u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .s0_valid (s0_valid_reg),
        .frame    (frame_reg),
        .s1_ready (s1_ready),
        .s1_valid (s1_valid),
        .s2_ready (s2_ready),
        .status   (status),
        .pos_out  (pos_s1),
        .prev_out (prev_s1)
    );

    bissc_motion #(
        .POS_BITS (POS_BITS)
    ) u_motion (
        .clk           (clk),
        .rst_n         (rst_n),
        .s1_valid      (s1_valid),
        .s2_ready      (s2_ready),
        .status        (status),
        .pos_in        (pos_s1),
        .prev_in       (prev_s1),
        .elec_offset   (elec_offset_reg),
        .pole_pairs    (pole_pairs_reg),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sync_found    (sync_found),
        .sync_position (sync_position),
        .position      (position),
        .speed_rpm_q8  (speed_rpm_q8),
        .elec_angle    (elec_angle)
    );

    // an empty input register never stalls
    `BISSC_ASSERT_NOW(a_empty_no_stall, !s0_valid_reg, !in_stall)
    // input stalls only when the whole pipe is backed up
    `BISSC_ASSERT_NOW(a_stall_backpressure, in_stall, out_valid && out_stall)
    // no sync means sync position reads zero
    `BISSC_ASSERT_NOW(a_nosync_pos_zero, out_valid && !sync_found, sync_position == '0)
    // pole pairs write lands in the register
    `BISSC_ASSERT_NEXT(a_pole_pairs_write,
        rst_n && cfg_we && (cfg_index == bissc_pkg::REG_POLE_PAIRS),
        pole_pairs_reg == $past(cfg_wdata[bissc_pkg::PP_W-1:0]))

endmodule

// ===== tb/testbench.sv =====
// testbench for the biss-c position decoder: directed and random frames checked against a decode model
module testbench;

    localparam int POS_W = bissc_pkg::POS_BITS_DEF;
    localparam int DATA_W = bissc_pkg::DATA_BITS_DEF;
    localparam int FRAME_W = bissc_pkg::FRAME_W;
    localparam int PIPE_LATENCY = 3;
    localparam int LONG_HOLD = 80;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [bissc_pkg::CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [bissc_pkg::CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic                             found;
        logic [bissc_pkg::SYNC_POS_W-1:0] sync_idx;
        logic [POS_W-1:0]                 pos;
        logic [bissc_pkg::SPEED_W-1:0]    speed;
        logic [POS_W-1:0]                 angle;
    } decode_t;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 in_valid = 1'b0;
    logic                                 in_stall;
    logic [FRAME_W-1:0]                   frame = '0;
    logic                                 out_valid;
    logic                                 out_stall = 1'b0;
    logic                                 sync_found;
    logic [bissc_pkg::SYNC_POS_W-1:0]     sync_position;
    logic [POS_W-1:0]                     position;
    logic signed [bissc_pkg::SPEED_W-1:0] speed_rpm_q8;
    logic [POS_W-1:0]                     elec_angle;
    logic                                 cfg_we = 1'b0;
    logic [bissc_pkg::CFG_INDEX_W-1:0]    cfg_index = '0;
    logic [POS_W-1:0]                     cfg_wdata = '0;

    // decode model state
    logic [POS_W-1:0]           model_offset = POS_W'(bissc_pkg::ELEC_OFFSET_RESET);
    logic [bissc_pkg::PP_W-1:0] pole_pairs_reg = bissc_pkg::POLE_PAIRS_RESET;
    logic [POS_W-1:0]           cur_pos = '0;
    logic [POS_W-1:0]           prev_pos = '0;
    logic                       speed_started = 1'b0;

    decode_t          predicted_decodes[$];
    decode_t          want;
    int               mismatch_count = 0;
    int               cycle_count = 0;
    bit               in_idle_en = 1'b0;
    bit               out_idle_en = 1'b0;
    bit               hold_request = 1'b0;
    logic [POS_W-1:0] stim_pos = '0;

    biss_c_position_decoder uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .frame         (frame),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sync_found    (sync_found),
        .sync_position (sync_position),
        .position      (position),
        .speed_rpm_q8  (speed_rpm_q8),
        .elec_angle    (elec_angle),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic decode_t decode_frame(input logic [FRAME_W-1:0] f);
        decode_t           r;
        logic [DATA_W-1:0] word;
        logic [POS_W-1:0]  delta;
        logic [POS_W-1:0]  rel;
        longint            scaled;
        logic [63:0]       prod;
        int                i;
        int                k;
        int                idx;
        r = '0;
        for (i = 0; i < FRAME_W - 2; i++)
        begin
            if (!r.found && !f[FRAME_W-1-i] && f[FRAME_W-2-i] && !f[FRAME_W-3-i])
            begin
                r.found = 1'b1;
                r.sync_idx = i[bissc_pkg::SYNC_POS_W-1:0];
            end
        end
        if (r.found)
        begin
            word = '0;
            for (k = 0; k < DATA_W; k++)
            begin
                idx = int'(r.sync_idx) + bissc_pkg::SYNC_BITS + k;
                word = {word[DATA_W-2:0], (idx < FRAME_W) ? f[FRAME_W-1-idx] : 1'b0};
            end
            cur_pos = word[bissc_pkg::WORD_SHIFT +: POS_W];
        end
        if (!speed_started)
        begin
            speed_started = 1'b1;
            r.speed = '0;
        end
        else
        begin
            delta = cur_pos - prev_pos;
            scaled = longint'($signed(delta)) * longint'(bissc_pkg::RPM_Q8_PER_TURN);
            scaled = scaled >>> POS_W;
            r.speed = scaled[bissc_pkg::SPEED_W-1:0];
        end
        prev_pos = cur_pos;
        rel = cur_pos - model_offset;
        prod = 64'(rel) * 64'(pole_pairs_reg);
        r.angle = prod[POS_W-1:0];
        r.pos = cur_pos;
        return r;
    endfunction

    // leading ones, 0-1-0 sync, then the data word carrying pos
    function automatic logic [FRAME_W-1:0] build_frame(input int sync_at,
                                                       input logic [POS_W-1:0] pos,
                                                       input logic [FRAME_W-1:0] fill);
        logic [FRAME_W-1:0] f;
        logic [DATA_W-1:0]  data;
        int                 idx;
        int                 k;
        data = {fill[DATA_W-1:POS_W+bissc_pkg::WORD_SHIFT], pos,
                fill[bissc_pkg::WORD_SHIFT-1:0]};
        f = fill;
        for (idx = 0; idx < sync_at; idx++)
            f[FRAME_W-1-idx] = 1'b1;
        f[FRAME_W-1-sync_at] = 1'b0;
        f[FRAME_W-2-sync_at] = 1'b1;
        f[FRAME_W-3-sync_at] = 1'b0;
        for (k = 0; k < DATA_W; k++)
        begin
            idx = sync_at + bissc_pkg::SYNC_BITS + k;
            if (idx < FRAME_W)
                f[FRAME_W-1-idx] = data[DATA_W-1-k];
        end
        return f;
    endfunction

    // runs of paired bits never hold an isolated one
    function automatic logic [FRAME_W-1:0] no_sync_frame();
        logic [FRAME_W-1:0] f;
        int                 k;
        f = '0;
        for (k = 0; k < FRAME_W / 2; k++)
            f[2*k +: 2] = ($urandom_range(0, 1) == 1) ? 2'b11 : 2'b00;
        return f;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && cfg_we)
        begin
            case (cfg_index)
                bissc_pkg::REG_ELEC_OFFSET: model_offset = cfg_wdata[POS_W-1:0];
                bissc_pkg::REG_POLE_PAIRS:  pole_pairs_reg = cfg_wdata[bissc_pkg::PP_W-1:0];
                default: ;
            endcase
        end
        if (rst_n && in_valid && !in_stall)
            predicted_decodes.push_back(decode_frame(frame));
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (predicted_decodes.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected transaction: found=%0d sync=%0d pos=%h speed=%0d",
                             sync_found, sync_position, position, speed_rpm_q8,
                             " angle=%h", elec_angle);
            end
            else
            begin
                want = predicted_decodes.pop_front();
                if (sync_found !== want.found || sync_position !== want.sync_idx ||
                    position !== want.pos || speed_rpm_q8 !== want.speed ||
                    elec_angle !== want.angle)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch exp found=%0d sync=%0d pos=%h speed=%0d angle=%h",
                                 want.found, want.sync_idx, want.pos, $signed(want.speed),
                                 want.angle, " got found=%0d sync=%0d pos=%h speed=%0d angle=%h",
                                 sync_found, sync_position, position, speed_rpm_q8,
                                 elec_angle);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("biss_c_position_decoder verification failed");
            $finish;
        end
    end

    // result side: random stall bursts and the long hold
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                out_stall <= 1'b0;
                hold_request = 1'b0;
            end
            else if (out_idle_en && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_frame(input logic [FRAME_W-1:0] f);
        if (in_idle_en && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid <= 1'b1;
        frame <= f;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (predicted_decodes.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [bissc_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [POS_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_sync_search();
        send_frame(build_frame(0, 20'hFFFFF, 64'h0));
        send_frame(64'hFFFF_FFFF_FFFF_FFFF);
        send_frame(64'h0);
        send_frame(64'hFFFF_FFFF_FFFF_FFFA);
        send_frame(build_frame(26, 20'h12345, {$urandom, $urandom}));
        send_frame(build_frame(40, 20'hFFFFF, 64'hFFFF_FFFF_FFFF_FFFF));
        send_frame(64'h5555_5555_5555_5555);
        send_frame(64'hCCCC_CCCC_CCCC_CCCC);
        wait_idle();
    endtask

    // steps of one count, the largest forward step and the half turn
    task automatic test_speed_wrap();
        send_frame(build_frame(0, 20'h00000, 64'h0));
        send_frame(build_frame(0, 20'h00001, 64'h0));
        send_frame(build_frame(0, 20'h00000, 64'h0));
        send_frame(build_frame(0, 20'h7FFFF, 64'h0));
        send_frame(build_frame(0, 20'hFFFFF, 64'h0));
        send_frame(build_frame(0, 20'h7FFFF, 64'h0));
        send_frame(build_frame(0, 20'h80000, 64'h0));
        send_frame(build_frame(0, 20'h00001, 64'h0));
        wait_idle();
    endtask

    task automatic test_config_regs();
        write_reg(bissc_pkg::REG_ELEC_OFFSET, 20'h00000);
        write_reg(bissc_pkg::REG_POLE_PAIRS, 20'h00001);
        send_frame(build_frame(3, 20'hABCDE, {$urandom, $urandom}));
        wait_idle();
        write_reg(bissc_pkg::REG_ELEC_OFFSET, 20'hFFFFF);
        write_reg(bissc_pkg::REG_POLE_PAIRS, 20'h00010);
        send_frame(build_frame(5, 20'h00000, {$urandom, $urandom}));
        wait_idle();
        write_reg(bissc_pkg::REG_POLE_PAIRS, 20'hFFFE0);
        send_frame(build_frame(1, 20'h3C3C3, {$urandom, $urandom}));
        wait_idle();
        write_reg(bissc_pkg::REG_POLE_PAIRS, 20'h0001F);
        write_reg(bissc_pkg::REG_ELEC_OFFSET, 20'h5A5A5);
        write_reg(REG_SPARE_2, 20'hFFFFF);
        write_reg(REG_SPARE_3, 20'h00001);
        send_frame(build_frame(9, 20'hC0FFE, {$urandom, $urandom}));
        wait_idle();
        write_reg(bissc_pkg::REG_ELEC_OFFSET, POS_W'(bissc_pkg::ELEC_OFFSET_RESET));
        write_reg(bissc_pkg::REG_POLE_PAIRS, POS_W'(bissc_pkg::POLE_PAIRS_RESET));
        send_frame(build_frame(2, 20'h00400, {$urandom, $urandom}));
        wait_idle();
    endtask

    task automatic test_output_hold();
        int n;
        in_idle_en = 1'b0;
        out_idle_en = 1'b0;
        hold_request = 1'b1;
        for (n = 0; n < 12; n++)
            send_frame(build_frame($urandom_range(0, 20), POS_W'($urandom),
                                   {$urandom, $urandom}));
        wait_idle();
    endtask

    task automatic random_frame();
        int               pick;
        int               sync_at;
        int               step;
        logic [POS_W-1:0] pos;
        pick = $urandom_range(0, 99);
        if (pick < 12)
            send_frame({$urandom, $urandom});
        else if (pick < 20)
            send_frame(no_sync_frame());
        else
        begin
            if ($urandom_range(0, 4) == 0)
                sync_at = $urandom_range(27, 61);
            else
                sync_at = $urandom_range(0, 26);
            case ($urandom_range(0, 3))
                0: pos = POS_W'($urandom);
                1:
                begin
                    step = $urandom_range(0, 4000) - 2000;
                    pos = stim_pos + step[POS_W-1:0];
                end
                2:
                begin
                    step = $urandom_range(0, 4);
                    pos = stim_pos + 20'h7FFFE + step[POS_W-1:0];
                end
                default: pos = stim_pos;
            endcase
            stim_pos = pos;
            send_frame(build_frame(sync_at, pos, {$urandom, $urandom}));
        end
    endtask

    task automatic test_random_phase(input logic [POS_W-1:0] offset_data,
                                     input logic [POS_W-1:0] pole_data,
                                     input int idle_items, input int busy_items);
        int n;
        write_reg(bissc_pkg::REG_ELEC_OFFSET, offset_data);
        write_reg(bissc_pkg::REG_POLE_PAIRS, pole_data);
        in_idle_en = 1'b1;
        out_idle_en = 1'b1;
        for (n = 0; n < idle_items; n++)
            random_frame();
        in_idle_en = 1'b0;
        out_idle_en = 1'b0;
        for (n = 0; n < busy_items; n++)
            random_frame();
        wait_idle();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_sync_search();
        test_speed_wrap();
        test_config_regs();
        test_output_hold();
        test_random_phase(POS_W'($urandom), POS_W'($urandom_range(1, 16)), 60, 10);
        test_random_phase(20'h00000, 20'h00001, 60, 10);
        test_random_phase(20'hFFFFF, 20'h00010, 60, 10);
        test_random_phase(POS_W'($urandom), POS_W'($urandom), 60, 10);
        test_random_phase(POS_W'($urandom), POS_W'(bissc_pkg::POLE_PAIRS_RESET), 60, 60);
        if (mismatch_count == 0 && predicted_decodes.size() == 0)
            $display("biss_c_position_decoder verification clean");
        else
            $display("biss_c_position_decoder verification failed");
        $finish;
    end

endmodule
